[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("port check failed");

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

[rtl/dhfd_pkg.sv]
// ----------------------------------------------------------------------------
// dhfd_pkg
// types and constants shared by the frame deframer controller and datapath
// ----------------------------------------------------------------------------
package dhfd_pkg;

	localparam int MaxPayload = 64;
	localparam int AddrW      = 6;
	localparam int LenW       = 7;
	localparam int PatBytes   = 4;

	localparam logic [31:0] AckHeaderReset  = 32'hFAFB_FCFD;
	localparam logic [31:0] AckFooterReset  = 32'h0102_0304;
	localparam logic [31:0] DataHeaderReset = 32'hF1F2_F3F4;
	localparam logic [31:0] DataFooterReset = 32'hF5F6_F7F8;

	// configuration register indexes
	localparam logic [1:0] RegAckHeader  = 2'd0;
	localparam logic [1:0] RegAckFooter  = 2'd1;
	localparam logic [1:0] RegDataHeader = 2'd2;
	localparam logic [1:0] RegDataFooter = 2'd3;

	// frame kinds
	localparam logic KindAck  = 1'b0;
	localparam logic KindData = 1'b1;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LENGTH,
		ST_PAYLOAD,
		ST_FOOTER,
		ST_EMIT
	} state_t;

	// datapath to controller
	typedef struct packed {
		logic hdr_hit;
		logic hdr_end;
		logic len_hi;
		logic len_big;
		logic len_zero;
		logic pay_end;
		logic foot_hit;
		logic foot_end;
		logic out_free;
		logic emit_end;
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic hunt;
		logic len_lo;
		logic len_hi;
		logic store;
		logic foot_adv;
		logic emit_start;
		logic emit_issue;
		logic restart;
	} cmd_t;

endpackage

[rtl/dhfd_ctrl.sv]
// ----------------------------------------------------------------------------
// dhfd_ctrl
// parse and readout sequencer of the frame deframer
// ----------------------------------------------------------------------------
module dhfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dhfd_pkg::status_t sts,
	output dhfd_pkg::cmd_t    cmd
);

	dhfd_pkg::state_t state_q, state_d;
	logic             acc;

	assign in_ready = (state_q != dhfd_pkg::ST_EMIT);
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhfd_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dhfd_pkg::ST_HUNT: begin
				if (acc && sts.hdr_end) state_d = dhfd_pkg::ST_LENGTH;
			end
			dhfd_pkg::ST_LENGTH: begin
				if (acc && sts.len_hi) begin
					if (sts.len_big)       state_d = dhfd_pkg::ST_HUNT;
					else if (sts.len_zero) state_d = dhfd_pkg::ST_FOOTER;
					else                   state_d = dhfd_pkg::ST_PAYLOAD;
				end
			end
			dhfd_pkg::ST_PAYLOAD: begin
				if (acc && sts.pay_end) state_d = dhfd_pkg::ST_FOOTER;
			end
			dhfd_pkg::ST_FOOTER: begin
				if (acc) begin
					if (!sts.foot_hit)     state_d = dhfd_pkg::ST_HUNT;
					else if (sts.foot_end) state_d = dhfd_pkg::ST_EMIT;
				end
			end
			dhfd_pkg::ST_EMIT: begin
				if (sts.out_free && sts.emit_end) state_d = dhfd_pkg::ST_HUNT;
			end
			default: state_d = dhfd_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			dhfd_pkg::ST_HUNT: begin
				cmd.hunt = acc;
			end
			dhfd_pkg::ST_LENGTH: begin
				cmd.len_lo  = acc && !sts.len_hi;
				cmd.len_hi  = acc && sts.len_hi && !sts.len_big;
				cmd.restart = acc && sts.len_hi && sts.len_big;
			end
			dhfd_pkg::ST_PAYLOAD: begin
				cmd.store = acc;
			end
			dhfd_pkg::ST_FOOTER: begin
				cmd.foot_adv   = acc && sts.foot_hit;
				cmd.emit_start = acc && sts.foot_hit && sts.foot_end;
				cmd.restart    = acc && !sts.foot_hit;
			end
			dhfd_pkg::ST_EMIT: begin
				cmd.emit_issue = sts.out_free;
				// kind and length are latched into the output word on the same edge
				cmd.restart    = sts.out_free && sts.emit_end;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/dhfd_datapath.sv]
// ----------------------------------------------------------------------------
// dhfd_datapath
// pattern registers, match and length tracking, payload memory, output word
// ----------------------------------------------------------------------------
module dhfd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic [7:0]                   rx_byte,
	input  dhfd_pkg::cmd_t               cmd,
	output dhfd_pkg::status_t            sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         out_kind,
	output logic [dhfd_pkg::LenW-1:0]    out_length,
	output logic [dhfd_pkg::AddrW-1:0]   out_position,
	output logic [7:0]                   out_payload,
	output logic                         out_has_byte,
	output logic                         out_last
);

	logic [31:0] ack_hdr_q, ack_ftr_q, data_hdr_q, data_ftr_q;

	logic [1:0]                  pos_q;
	logic                        len_hi_q;
	logic [7:0]                  len_lo_q;
	logic [dhfd_pkg::LenW-1:0]   len_q;
	logic [dhfd_pkg::LenW-1:0]   stored_q;
	logic                        kind_q;
	logic [dhfd_pkg::AddrW-1:0]  rd_idx_q;

	logic [7:0] store_mem [dhfd_pkg::MaxPayload];
	logic [7:0] rd_data_q;

	logic                        out_valid_q, kind_out_q, has_out_q, last_out_q;
	logic [dhfd_pkg::LenW-1:0]   len_out_q;
	logic [dhfd_pkg::AddrW-1:0]  pos_out_q;

	logic [7:0]                  ack_hdr_byte, data_hdr_byte, ftr_byte;
	logic                        ack_hit, data_hit, first_hit;
	logic [15:0]                 len_full;
	logic [dhfd_pkg::LenW-1:0]   stored_inc, rd_next;
	logic                        is_last;

	assign ack_hdr_byte  = ack_hdr_q[8*pos_q +: 8];
	assign data_hdr_byte = data_hdr_q[8*pos_q +: 8];
	assign ftr_byte      = (kind_q == dhfd_pkg::KindData) ? data_ftr_q[8*pos_q +: 8]
	                                                      : ack_ftr_q[8*pos_q +: 8];
	assign ack_hit   = (rx_byte == ack_hdr_byte);
	assign data_hit  = (rx_byte == data_hdr_byte);
	assign first_hit = (rx_byte == ack_hdr_q[7:0]) || (rx_byte == data_hdr_q[7:0]);

	// little-endian length, low byte came first
	assign len_full   = {rx_byte, len_lo_q};
	assign stored_inc = stored_q + dhfd_pkg::LenW'(1);
	assign rd_next    = {1'b0, rd_idx_q} + dhfd_pkg::LenW'(1);
	assign is_last    = (len_q == '0) || (rd_next == len_q);

	always_comb begin
		sts.hdr_hit  = ack_hit || data_hit;
		sts.hdr_end  = (ack_hit || data_hit) && (pos_q == 2'(dhfd_pkg::PatBytes - 1));
		sts.len_hi   = len_hi_q;
		sts.len_big  = (len_full > 16'(dhfd_pkg::MaxPayload));
		sts.len_zero = (len_full == '0);
		sts.pay_end  = (stored_inc >= len_q);
		sts.foot_hit = (rx_byte == ftr_byte);
		sts.foot_end = (pos_q == 2'(dhfd_pkg::PatBytes - 1));
		sts.out_free = !out_valid_q || out_ready;
		sts.emit_end = is_last;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_hdr_q  <= dhfd_pkg::AckHeaderReset;
			ack_ftr_q  <= dhfd_pkg::AckFooterReset;
			data_hdr_q <= dhfd_pkg::DataHeaderReset;
			data_ftr_q <= dhfd_pkg::DataFooterReset;
		end else if (cfg_we) begin
			case (cfg_index)
				dhfd_pkg::RegAckHeader:  ack_hdr_q  <= cfg_data;
				dhfd_pkg::RegAckFooter:  ack_ftr_q  <= cfg_data;
				dhfd_pkg::RegDataHeader: data_hdr_q <= cfg_data;
				dhfd_pkg::RegDataFooter: data_ftr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_hi_q <= 1'b0;
			len_lo_q <= '0;
			len_q    <= '0;
			stored_q <= '0;
			kind_q   <= dhfd_pkg::KindAck;
			rd_idx_q <= '0;
		end else begin
			if (cmd.hunt) begin
				if (ack_hit || data_hit) begin
					if (pos_q == 2'(dhfd_pkg::PatBytes - 1)) begin
						kind_q   <= ack_hit ? dhfd_pkg::KindAck : dhfd_pkg::KindData;
						pos_q    <= '0;
						len_hi_q <= 1'b0;
						stored_q <= '0;
					end else begin
						pos_q <= pos_q + 2'd1;
					end
				end else begin
					// a miss may still open a fresh header
					pos_q <= first_hit ? 2'd1 : 2'd0;
				end
			end
			if (cmd.len_lo) begin
				len_lo_q <= rx_byte;
				len_hi_q <= 1'b1;
			end
			if (cmd.len_hi) begin
				len_q    <= len_lo_q[dhfd_pkg::LenW-1:0];
				len_hi_q <= 1'b0;
				pos_q    <= '0;
			end
			if (cmd.store) begin
				stored_q <= stored_inc;
			end
			if (cmd.foot_adv) begin
				pos_q <= pos_q + 2'd1;
			end
			if (cmd.emit_start) begin
				rd_idx_q <= '0;
			end
			if (cmd.emit_issue) begin
				rd_idx_q <= rd_idx_q + dhfd_pkg::AddrW'(1);
			end
			if (cmd.restart) begin
				pos_q    <= '0;
				len_hi_q <= 1'b0;
				len_lo_q <= '0;
				len_q    <= '0;
				stored_q <= '0;
				kind_q   <= dhfd_pkg::KindAck;
			end
		end
	end

	// payload memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_mem[stored_q[dhfd_pkg::AddrW-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_issue) begin
			rd_data_q <= store_mem[rd_idx_q];
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_issue) begin
			kind_out_q <= kind_q;
			len_out_q  <= len_q;
			pos_out_q  <= rd_idx_q;
			has_out_q  <= (len_q != '0);
			last_out_q <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_out_q;
	assign out_length   = len_out_q;
	assign out_position = pos_out_q;
	assign out_payload  = has_out_q ? rd_data_q : 8'd0;
	assign out_has_byte = has_out_q;
	assign out_last     = last_out_q;

endmodule

[rtl/dual_header_frame_deframer.sv]
// ----------------------------------------------------------------------------
// dual_header_frame_deframer
// byte-stream deframer for command-ack and data frames with payload readout
// ----------------------------------------------------------------------------
// Received bytes enter one per cycle on the slave stream while a frame is parsed:
// either 4-byte header, a 16-bit little-endian length (at most 64), the payload
// and the footer of that frame kind. After a good footer the frame is read back
// from the 64-byte payload memory, one word per cycle through its single read
// port when the master side never stalls, max(length, 1) words; s_axis_tready is
// low during readout. Header and footer patterns are set via cfg_we / cfg_index /
// cfg_data; the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module dual_header_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] frame_length, [12:7] byte_position, [20:13] payload_value,
	// [21] has_payload_byte, [23:22] zero
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast,   // last_of_frame
	output logic        m_axis_tuser    // [0] kind_of_frame
);

	dhfd_pkg::status_t sts;
	dhfd_pkg::cmd_t    cmd;

	logic [dhfd_pkg::LenW-1:0]  out_length;
	logic [dhfd_pkg::AddrW-1:0] out_position;
	logic [7:0]                 out_payload;
	logic                       out_has_byte;

	dhfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dhfd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rx_byte      (s_axis_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_kind     (m_axis_tuser),
		.out_length   (out_length),
		.out_position (out_position),
		.out_payload  (out_payload),
		.out_has_byte (out_has_byte),
		.out_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, out_has_byte, out_payload, out_position, out_length};

endmodule

[rtl/dhfd_checker.sv]
// ----------------------------------------------------------------------------
// dhfd_checker
// port-level checks on the deframer output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// a stalled word holds
	`ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

	// empty frame word is a lone last word of length zero
	`ASSERT_CLK(a_empty_word, m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tlast && (m_axis_tdata[6:0] == 7'd0))

	// real byte: nonzero length, last exactly at the final position
	`ASSERT_CLK(a_last_pos, m_axis_tvalid && m_axis_tdata[21] |-> (m_axis_tdata[6:0] != 7'd0) && (m_axis_tlast == (({1'b0, m_axis_tdata[12:7]} + 7'd1) == m_axis_tdata[6:0])))

	// readout runs without gaps and positions count up
	`ASSERT_CLK(a_pos_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && (m_axis_tdata[12:7] == $past(m_axis_tdata[12:7]) + 6'd1))

	// no byte taken in while a frame is still being read out
	`ASSERT_NEVER(a_no_rx_in_burst, m_axis_tvalid && !m_axis_tlast && s_axis_tready)

endmodule

bind dual_header_frame_deframer dhfd_checker u_chk (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stream-level check of the two-header frame deframer
// ----------------------------------------------------------------------------
// A table of whole frames runs first. It covers both kinds, empty and full
// payloads, oversize lengths, broken footers, interleaved headers and a header
// that restarts on its own first byte. Random frames mixed with noise follow,
// under several header and footer settings. Every accepted byte goes through
// a local frame parser that queues expected words (typed table rows carry their
// own). Returned words are checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module testbench;
	import dhfd_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int NoCut      = -1;
	localparam int HoldCycles = 400;

	typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct packed {
		logic            kind;
		logic [LenW-1:0] len;
		logic [5:0]      pos;
		logic [7:0]      val;
		logic            has;
		logic            last;
	} frame_word_t;

	typedef struct {
		logic [7:0]  b;
		bit          fixed;
		bit          gives_word;
		frame_word_t word;
	} rx_item_t;

	typedef struct {
		logic        kind;
		bit          mix;
		bit          stutter;
		logic [15:0] len;
		fill_t       fill;
		int          cut;
		bit          typed;
		bit          want_word;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = RegAckHeader;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	dual_header_frame_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// parser copy: patterns and frame state
	logic [31:0]     ack_hdr   = AckHeaderReset;
	logic [31:0]     ack_foot  = AckFooterReset;
	logic [31:0]     data_hdr  = DataHeaderReset;
	logic [31:0]     data_foot = DataFooterReset;
	state_t          phase     = ST_HUNT;
	logic [1:0]      mpos      = '0;
	bit              len_hi_due;
	logic [15:0]     decl_len  = '0;
	logic [LenW-1:0] stored    = '0;
	logic            cur_kind  = KindAck;
	logic [7:0]      store_mem [MaxPayload];
	frame_word_t     burst_words [MaxPayload];

	rx_item_t        tx_bytes [$];
	frame_word_t     words_due [$];
	bit              in_flight;
	bit              calm;
	bit              hold_req;
	int              queued;
	int              errors;
	int              cycles;

	frame_row_t dir_rows [13] = '{
		'{KindAck,  0, 0, 16'd0,    FILL_ZERO, NoCut, 1, 1},  // empty ack frame
		'{KindData, 0, 0, 16'd0,    FILL_ZERO, NoCut, 1, 1},  // empty data frame
		'{KindAck,  0, 0, 16'd1,    FILL_ZERO, NoCut, 0, 0},
		'{KindData, 0, 0, 16'd64,   FILL_ONES, NoCut, 0, 0},  // full store
		'{KindAck,  0, 0, 16'd20,   FILL_RAND, NoCut, 0, 0},
		'{KindAck,  0, 0, 16'd65,   FILL_RAND, NoCut, 1, 0},  // one above the store
		'{KindData, 0, 0, 16'hFFFF, FILL_RAND, NoCut, 1, 0},
		'{KindAck,  0, 0, 16'h0100, FILL_RAND, NoCut, 1, 0},  // low byte alone would fit
		'{KindData, 0, 0, 16'd3,    FILL_RAND, 0,     1, 0},  // footer breaks at once
		'{KindAck,  0, 0, 16'd2,    FILL_RAND, 3,     1, 0},  // footer breaks at the end
		'{KindData, 1, 0, 16'd2,    FILL_RAND, NoCut, 0, 0},  // headers interleaved
		'{KindAck,  1, 1, 16'd5,    FILL_RAND, NoCut, 0, 0},
		'{KindData, 0, 1, 16'd7,    FILL_RAND, NoCut, 0, 0}   // hunt restarts on byte 0
	};

	function automatic logic [7:0] lane(input logic [31:0] pat, input int idx);
		return pat[8*idx +: 8];
	endfunction

	task automatic restart_parse();
		phase      = ST_HUNT;
		mpos       = '0;
		len_hi_due = 0;
		decl_len   = '0;
		stored     = '0;
		cur_kind   = KindAck;
	endtask

	// advance the parser by one byte; fills burst_words on a good footer
	task automatic parse_byte(input logic [7:0] b, output int n);
		logic [31:0] foot;
		n = 0;
		case (phase)
			ST_HUNT: begin
				if (b == lane(ack_hdr, mpos) || b == lane(data_hdr, mpos)) begin
					if (mpos == 2'd3) begin
						cur_kind   = (b == lane(ack_hdr, mpos)) ? KindAck : KindData;
						phase      = ST_LENGTH;
						mpos       = '0;
						len_hi_due = 0;
						stored     = '0;
					end else begin
						mpos = mpos + 2'd1;
					end
				end else begin
					mpos = (b == lane(ack_hdr, 0) || b == lane(data_hdr, 0)) ? 2'd1 : 2'd0;
				end
			end
			ST_LENGTH: begin
				if (!len_hi_due) begin
					decl_len   = {8'h00, b};
					len_hi_due = 1;
				end else begin
					decl_len[15:8] = b;
					len_hi_due     = 0;
					if (decl_len > MaxPayload) begin
						restart_parse();
					end else if (decl_len == 0) begin
						phase = ST_FOOTER;
						mpos  = '0;
					end else begin
						phase = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				store_mem[stored[5:0]] = b;
				stored = stored + 1'b1;
				if (stored >= decl_len) begin
					phase = ST_FOOTER;
					mpos  = '0;
				end
			end
			default: begin
				foot = (cur_kind == KindData) ? data_foot : ack_foot;
				if (b != lane(foot, mpos)) begin
					restart_parse();
				end else if (mpos != 2'd3) begin
					mpos = mpos + 2'd1;
				end else begin
					if (decl_len == 0) begin
						burst_words[0] = '{cur_kind, '0, '0, '0, 1'b0, 1'b1};
						n = 1;
					end else begin
						for (int k = 0; k < decl_len; k++)
							burst_words[k] = '{cur_kind, decl_len[LenW-1:0], k[5:0],
								store_mem[k], 1'b1, k == decl_len - 1};
						n = decl_len;
					end
					restart_parse();
				end
			end
		endcase
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			RegAckHeader:  ack_hdr   = val;
			RegAckFooter:  ack_foot  = val;
			RegDataHeader: data_hdr  = val;
			RegDataFooter: data_foot = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit fixed);
		rx_item_t it;
		it.b          = b;
		it.fixed      = fixed;
		it.gives_word = 0;
		it.word       = '0;
		tx_bytes.push_back(it);
		queued++;
	endtask

	task automatic add_frame(input frame_row_t row);
		logic [31:0] hdr, alt, foot;
		logic [7:0]  bad;
		hdr  = row.kind ? data_hdr : ack_hdr;
		alt  = row.kind ? ack_hdr : data_hdr;
		foot = row.kind ? data_foot : ack_foot;
		if (row.stutter) begin
			queue_byte(lane(hdr, 0), row.typed);
			queue_byte(lane(hdr, 1), row.typed);
		end
		for (int i = 0; i < PatBytes; i++)
			queue_byte((row.mix && i % 2 == 0) ? lane(alt, i) : lane(hdr, i), row.typed);
		queue_byte(row.len[7:0], row.typed);
		queue_byte(row.len[15:8], row.typed);
		if (row.len > MaxPayload)
			return;
		for (int k = 0; k < row.len; k++)
			case (row.fill)
				FILL_ZERO: queue_byte(8'h00, row.typed);
				FILL_ONES: queue_byte(8'hFF, row.typed);
				default:   queue_byte(8'($urandom), row.typed);
			endcase
		for (int i = 0; i < PatBytes; i++) begin
			if (i == row.cut) begin
				// a header start byte here must be dropped, not hunted from
				bad = lane(ack_hdr, 0);
				if (bad == lane(foot, i))
					bad = ~bad;
				queue_byte(bad, row.typed);
				for (int j = 1; j < PatBytes; j++)
					queue_byte(lane(ack_hdr, j), row.typed);
				return;
			end
			queue_byte(lane(foot, i), row.typed);
		end
		if (row.typed && row.want_word) begin
			tx_bytes[tx_bytes.size()-1].gives_word = 1;
			tx_bytes[tx_bytes.size()-1].word = '{row.kind, '0, '0, '0, 1'b0, 1'b1};
		end
	endtask

	task automatic add_random_frame();
		frame_row_t row;
		int pick;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				queue_byte(($urandom_range(0, 3) == 0) ? lane(data_hdr, 0) : 8'($urandom),
					0);
		pick        = $urandom_range(0, 99);
		row.kind    = 1'($urandom_range(0, 1));
		row.mix     = $urandom_range(0, 3) == 0;
		row.stutter = $urandom_range(0, 7) == 0;
		row.fill    = FILL_RAND;
		row.cut     = NoCut;
		row.typed   = 0;
		row.want_word = 0;
		if (pick < 8) begin
			row.len = 16'($urandom_range(MaxPayload + 1, 65535));
		end else begin
			case ($urandom_range(0, 11))
				0:       row.len = 16'd0;
				1:       row.len = 16'(MaxPayload);
				2:       row.len = 16'($urandom_range(17, MaxPayload - 1));
				default: row.len = 16'($urandom_range(1, 16));
			endcase
			if (pick < 18)
				row.cut = $urandom_range(0, PatBytes - 1);
		end
		add_frame(row);
	endtask

	// phases end on a good frame so the parser is back to hunting
	task automatic add_random_bytes(input int count);
		frame_row_t row;
		int goal;
		goal = queued + count;
		while (queued < goal)
			add_random_frame();
		row = '{1'($urandom_range(0, 1)), 0, 0, 16'($urandom_range(1, 8)), FILL_RAND,
			NoCut, 0, 0};
		add_frame(row);
	endtask

	task automatic settle(input int tail);
		do
			@(posedge clk);
		while (tx_bytes.size() != 0 || in_flight || words_due.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	// sender
	initial begin
		rx_item_t cur;
		int n;
		int gap;
		gap = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) begin
				parse_byte(cur.b, n);
				if (cur.fixed) begin
					if (cur.gives_word)
						words_due.push_back(cur.word);
				end else begin
					for (int k = 0; k < n; k++)
						words_due.push_back(burst_words[k]);
				end
				in_flight = 0;
			end
			if (!in_flight) begin
				if (gap > 0) begin
					gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					cur = tx_bytes.pop_front();
					in_flight = 1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= cur.b;
					if (!calm && $urandom_range(0, 5) == 0)
						gap = $urandom_range(1, 19);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver
	initial begin
		frame_word_t got, want;
		int hold;
		int gap;
		hold = 0;
		gap  = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[12:7],
					m_axis_tdata[20:13], m_axis_tdata[21], m_axis_tlast};
				if (words_due.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t: word with none due, expected nothing got %h", $time, got);
				end else begin
					want = words_due.pop_front();
					check_field("kind_of_frame", want.kind, got.kind);
					check_field("frame_length", want.len, got.len);
					check_field("byte_position", want.pos, got.pos);
					check_field("payload_value", want.val, got.val);
					check_field("has_payload_byte", want.has, got.has);
					check_field("last_of_frame", want.last, got.last);
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold = HoldCycles;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					gap = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			add_frame(dir_rows[i]);
		settle(24);

		// long output stall while bytes keep coming, then a full pause
		hold_req = 1;
		add_random_bytes(20);
		settle(0);
		add_random_bytes(15);
		settle(24);

		write_reg(RegAckHeader,  32'h0000_0000);
		write_reg(RegAckFooter,  32'hFFFF_FFFF);
		write_reg(RegDataHeader, 32'hFFFF_FFFF);
		write_reg(RegDataFooter, 32'h0000_0000);
		add_random_bytes(15);
		settle(24);

		write_reg(RegAckHeader,  $urandom);
		write_reg(RegAckFooter,  $urandom);
		write_reg(RegDataHeader, $urandom);
		write_reg(RegDataFooter, $urandom);
		add_random_bytes(15);
		settle(24);

		write_reg(RegDataHeader, $urandom);
		write_reg(RegAckFooter,  $urandom);
		calm = 1;
		add_random_bytes(10);
		settle(80);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dhfd_pkg.sv
rtl/dhfd_ctrl.sv
rtl/dhfd_datapath.sv
rtl/dual_header_frame_deframer.sv
rtl/dhfd_checker.sv
verif/testbench.sv
